/* src/deg_pkg.sv */
// Shared types, constants and helpers of the dynamic EQ gain computer.
package deg_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int CFG_DATA_BITS   = 16;
  localparam int GAIN_BITS       = 14;
  localparam int LEVEL_BITS      = 16;
  localparam int MUL_BITS        = 32;
  localparam int NUM_BITS        = 48;
  localparam int DEN_BITS        = 32;
  localparam int QUOT_BITS       = 17;
  localparam int GAIN_SUM_BITS   = 19;

  localparam logic signed [LEVEL_BITS-1:0] DB_FLOOR = -16'sd30720;
  localparam int GAIN_LIMIT = 7680;
  localparam logic [26:0] LOG_SCALE = 27'd101008905;

  localparam logic signed [15:0] THRESHOLD_RESET = -16'sd5120;
  localparam logic [14:0] RATIO_RESET   = 15'd512;
  localparam logic [12:0] KNEE_RESET    = 13'd1536;
  localparam logic [15:0] ATTACK_RESET  = 16'd65398;
  localparam logic [15:0] RELEASE_RESET = 16'd65522;
  localparam logic [14:0] RATIO_UNITY   = 15'd256;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_THRESHOLD,
    REG_RATIO,
    REG_KNEE,
    REG_MAKEUP,
    REG_ATTACK,
    REG_RELEASE,
    REG_MODE,
    REG_MANUAL
  } reg_index_t;

  typedef enum logic [1:0] {
    MODE_AUTO,
    MODE_SIDECHAIN,
    MODE_MANUAL
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ENV_OLD,
    S_ENV_NEW,
    S_NORM,
    S_LOG,
    S_SCALE,
    S_GAIN,
    S_KNEE_SQ,
    S_KNEE_NUM,
    S_KNEE_DEN,
    S_DIV,
    S_FIN
  } state_t;

  function automatic logic signed [GAIN_BITS-1:0] clamp_gain(
    input logic signed [GAIN_SUM_BITS-1:0] g
  );
    if (g > GAIN_LIMIT) return GAIN_BITS'(GAIN_LIMIT);
    if (g < -GAIN_LIMIT) return GAIN_BITS'(-GAIN_LIMIT);
    return GAIN_BITS'(g);
  endfunction

endpackage

/* src/deg_if.sv */
// Item and result channel interfaces of the dynamic EQ gain computer.
interface deg_item_if #(parameter int SAMPLE_BITS = deg_pkg::SAMPLE_BITS_DEF);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_left;
  logic signed [SAMPLE_BITS-1:0] sample_right;
  logic        [SAMPLE_BITS-1:0] sidechain_level;
  modport source(output valid, sample_left, sample_right, sidechain_level, input ready);
  modport sink(input valid, sample_left, sample_right, sidechain_level, output ready);
endinterface

interface deg_result_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [deg_pkg::GAIN_BITS-1:0]  gain_change;
  logic signed [deg_pkg::LEVEL_BITS-1:0] detected_level;
  modport source(output valid, gain_change, detected_level, input ready);
  modport sink(input valid, gain_change, detected_level, output ready);
endinterface

/* src/deg_mul.sv */
// Shared unsigned multiplier used by every multiply step of the sequencer.
module deg_mul (
  input  logic [deg_pkg::MUL_BITS-1:0]   a,
  input  logic [deg_pkg::MUL_BITS-1:0]   b,
  output logic [2*deg_pkg::MUL_BITS-1:0] p
);
  import deg_pkg::*;

  assign p = (2*MUL_BITS)'(a) * (2*MUL_BITS)'(b);

endmodule

/* src/deg_div.sv */
// Restoring divider that finds one quotient bit per cycle.
module deg_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [deg_pkg::NUM_BITS-1:0]  num,
  input  logic [deg_pkg::DEN_BITS-1:0]  den,
  output logic                          done,
  output logic [deg_pkg::QUOT_BITS-1:0] quot
);
  import deg_pkg::*;

  localparam int CNT_BITS = $clog2(QUOT_BITS);

  logic [NUM_BITS-1:0] rem;
  logic [NUM_BITS-1:0] dsh;
  logic [CNT_BITS-1:0] cnt;
  logic                busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= num;
        dsh  <= NUM_BITS'(den) << (QUOT_BITS - 1);
        cnt  <= CNT_BITS'(QUOT_BITS - 1);
        quot <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (rem >= dsh) begin
          rem       <= rem - dsh;
          quot[cnt] <= 1'b1;
        end
        dsh <= dsh >> 1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

/* src/dynamic_eq_gain_computer.sv */
// Top level of the dynamic EQ gain computer: sequencer, registers and datapath.
//
// The user must write configuration through cfg_write, cfg_index and cfg_data
// only while the block is idle; the block itself does not enforce this. Each
// beat on the item channel carries one stereo sample pair and a sidechain
// level; each item gives exactly one beat on the result channel with the gain
// change and the detected level in 1/256 dB. In auto mode the peak envelope is
// updated, in sidechain mode the supplied level is used, and in manual mode the
// fixed value is returned at once. The level goes through a one-bit-per-cycle
// normalizing shift, 16 squaring steps on the shared multiplier, a scaling
// multiply, the gain curve (up to three more multiplies) and a 17-step divider.
// The longest case is a small auto level inside the knee, set by the shift and
// the divider wait.
// The item channel is ready only while the sequencer is idle. The result sits
// in an output register, so the next item is taken while a result waits; a
// finished item holds in its last step until the register is free.
// Reset restores the register defaults, clears the envelope and empties the
// output register.
module dynamic_eq_gain_computer #(
  parameter int SAMPLE_BITS = deg_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [deg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [deg_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  deg_item_if.sink                           item,
  deg_result_if.source                       result
);
  import deg_pkg::*;

  localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
  localparam logic [4:0] TOP_P = 5'(SAMPLE_BITS - 1);

  // Configuration registers.
  logic signed [15:0] threshold;
  logic        [14:0] ratio;
  logic        [12:0] knee;
  logic signed [13:0] makeup;
  logic        [15:0] attack;
  logic        [15:0] release_coef;
  logic        [1:0]  mode;
  logic signed [13:0] manual;

  state_t state, state_next;

  logic [SAMPLE_BITS-1:0]  env;
  logic [SAMPLE_BITS-1:0]  raw;
  logic [NUM_BITS-1:0]     acc;
  logic [31:0]             x;
  logic [4:0]              pp;
  logic [30:0]             m;
  logic [3:0]              cnt;
  logic [15:0]             frac;
  logic signed [15:0]      db;
  logic [13:0]             s;
  logic [QUOT_BITS-1:0]    quot;

  logic                    out_valid;
  logic signed [13:0]      out_gain;
  logic signed [15:0]      out_level;

  logic [MUL_BITS-1:0]     mul_a, mul_b;
  logic [2*MUL_BITS-1:0]   prod;
  logic                    div_start, div_done;
  logic [NUM_BITS-1:0]     div_num;
  logic [DEN_BITS-1:0]     div_den;
  logic [QUOT_BITS-1:0]    div_quot;

  logic                       accept;
  logic                       out_free;
  logic signed [SAMPLE_BITS:0] pair_sum;
  logic [SAMPLE_BITS:0]       pair_abs;
  logic [SAMPLE_BITS-1:0]     side_sat;
  logic [15:0]                coef;
  logic [16:0]                coef_comp;
  logic [63:0]                env_sum;
  logic [31:0]                sq;
  logic [20:0]                neg;
  logic [63:0]                mag_sum;
  logic [31:0]                mag;
  logic signed [16:0]         o;
  logic signed [18:0]         two_o;
  logic signed [18:0]         k_s;
  logic                       no_cut;
  logic                       in_knee;
  logic [14:0]                ratio_excess;
  logic signed [GAIN_SUM_BITS-1:0] gain_sum;

  assign accept     = item.valid && item.ready;
  assign item.ready = (state == S_IDLE);
  assign out_free   = !out_valid || result.ready;

  assign pair_sum = (SAMPLE_BITS+1)'(item.sample_left) + (SAMPLE_BITS+1)'(item.sample_right);
  assign pair_abs = pair_sum[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-pair_sum)
                                          : (SAMPLE_BITS+1)'(pair_sum);
  assign side_sat = (item.sidechain_level > FULL_SCALE) ? FULL_SCALE : item.sidechain_level;

  assign coef      = (raw > env) ? attack : release_coef;
  assign coef_comp = 17'h10000 - 17'(coef);
  assign env_sum   = 64'(acc) + prod + 64'd32768;
  assign sq        = prod[61:30];
  assign neg       = {TOP_P - pp, 16'h0000} - 21'(frac);
  assign mag_sum   = prod + 64'h0000_0000_8000_0000;
  assign mag       = mag_sum[63:32];

  assign o            = 17'(db) - 17'(threshold);
  assign two_o        = {o[16], o, 1'b0};
  assign k_s          = $signed(19'(knee));
  assign no_cut       = (ratio <= RATIO_UNITY) || (two_o <= -k_s);
  assign in_knee      = (two_o < k_s);
  assign ratio_excess = ratio - RATIO_UNITY;

  assign gain_sum = (mode == MODE_MANUAL) ? GAIN_SUM_BITS'(manual)
                  : GAIN_SUM_BITS'(makeup) - $signed(GAIN_SUM_BITS'(quot));

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_ENV_OLD: begin
        mul_a = 32'(coef);
        mul_b = 32'(env);
      end
      S_ENV_NEW: begin
        mul_a = 32'(coef_comp);
        mul_b = 32'(raw);
      end
      S_LOG: begin
        mul_a = 32'(m);
        mul_b = 32'(m);
      end
      S_SCALE: begin
        mul_a = 32'(neg);
        mul_b = 32'(LOG_SCALE);
      end
      S_GAIN: begin
        mul_a = 32'(ratio_excess);
        mul_b = 32'($unsigned(o));
      end
      S_KNEE_SQ: begin
        mul_a = 32'(s);
        mul_b = 32'(s);
      end
      S_KNEE_NUM: begin
        mul_a = 32'(ratio_excess);
        mul_b = 32'(acc[27:0]);
      end
      S_KNEE_DEN: begin
        mul_a = 32'(knee);
        mul_b = 32'(ratio);
      end
      default: ;
    endcase
  end

  // The knee denominator is 8*k*r; the divider sees twice the numerator plus it.
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state)
      S_GAIN: begin
        div_start = !no_cut && !in_knee;
        div_num   = NUM_BITS'(prod << 1) + NUM_BITS'(ratio);
        div_den   = DEN_BITS'(ratio) << 1;
      end
      S_KNEE_DEN: begin
        div_start = 1'b1;
        div_num   = NUM_BITS'(acc << 1) + NUM_BITS'(prod << 3);
        div_den   = DEN_BITS'(prod << 4);
      end
      default: ;
    endcase
  end

  deg_mul u_mul (
    .a (mul_a),
    .b (mul_b),
    .p (prod)
  );

  deg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= THRESHOLD_RESET;
      ratio        <= RATIO_RESET;
      knee         <= KNEE_RESET;
      makeup       <= '0;
      attack       <= ATTACK_RESET;
      release_coef <= RELEASE_RESET;
      mode         <= MODE_AUTO;
      manual       <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_THRESHOLD: threshold    <= $signed(cfg_data[15:0]);
        REG_RATIO:     ratio        <= cfg_data[14:0];
        REG_KNEE:      knee         <= cfg_data[12:0];
        REG_MAKEUP:    makeup       <= $signed(cfg_data[13:0]);
        REG_ATTACK:    attack       <= cfg_data[15:0];
        REG_RELEASE:   release_coef <= cfg_data[15:0];
        REG_MODE:      mode         <= cfg_data[1:0];
        REG_MANUAL:    manual       <= $signed(cfg_data[13:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (mode == MODE_MANUAL) state_next = S_FIN;
          else if (mode == MODE_SIDECHAIN) state_next = S_NORM;
          else state_next = S_ENV_OLD;
        end
      end
      S_ENV_OLD:  state_next = S_ENV_NEW;
      S_ENV_NEW:  state_next = S_NORM;
      S_NORM: begin
        if (x == '0) state_next = S_GAIN;
        else if (x[31]) state_next = S_LOG;
      end
      S_LOG:      if (cnt == '0) state_next = S_SCALE;
      S_SCALE:    state_next = S_GAIN;
      S_GAIN: begin
        if (no_cut) state_next = S_FIN;
        else if (in_knee) state_next = S_KNEE_SQ;
        else state_next = S_DIV;
      end
      S_KNEE_SQ:  state_next = S_KNEE_NUM;
      S_KNEE_NUM: state_next = S_KNEE_DEN;
      S_KNEE_DEN: state_next = S_DIV;
      S_DIV:      if (div_done) state_next = S_FIN;
      S_FIN:      if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      env <= '0;
    end else if (state == S_ENV_NEW) begin
      env <= env_sum[SAMPLE_BITS+15:16];
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        raw <= pair_abs[SAMPLE_BITS:1];
        x   <= 32'(side_sat);
        pp  <= 5'd31;
        db  <= DB_FLOOR;
      end
      S_ENV_OLD: acc <= NUM_BITS'(prod);
      S_ENV_NEW: begin
        x  <= 32'(env_sum[SAMPLE_BITS+15:16]);
        pp <= 5'd31;
      end
      S_NORM: begin
        if (x == '0) begin
          db <= DB_FLOOR;
        end else if (x[31]) begin
          m    <= x[31:1];
          cnt  <= 4'd15;
          frac <= '0;
        end else begin
          x  <= x << 1;
          pp <= pp - 5'd1;
        end
      end
      S_LOG: begin
        // Each squaring doubles the log; an overflow past 2.0 yields a one bit.
        if (sq[31]) begin
          m         <= sq[31:1];
          frac[cnt] <= 1'b1;
        end else begin
          m <= sq[30:0];
        end
        cnt <= cnt - 4'd1;
      end
      S_SCALE: begin
        if (pp == TOP_P) db <= '0;
        else if (mag > 32'd30720) db <= DB_FLOOR;
        else db <= -$signed(16'(mag));
      end
      S_GAIN: begin
        quot <= '0;
        s    <= 14'(two_o + k_s);
      end
      S_KNEE_SQ:  acc <= NUM_BITS'(prod);
      S_KNEE_NUM: acc <= NUM_BITS'(prod);
      S_DIV:      if (div_done) quot <= div_quot;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      out_valid <= 1'b1;
      out_gain  <= clamp_gain(gain_sum);
      out_level <= db;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign result.valid          = out_valid;
  assign result.gain_change    = out_gain;
  assign result.detected_level = out_level;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("sequencer stayed idle after an accepted beat");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside its wait step");

  a_log_normalized: assert property (@(posedge clk) disable iff (rst)
    state == S_LOG |-> m[30])
    else $error("log mantissa lost its leading one");

  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_gain <= GAIN_LIMIT && out_gain >= -GAIN_LIMIT))
    else $error("gain change outside the clamp range");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_level <= 0 && out_level >= DB_FLOOR))
    else $error("detected level outside its range");

endmodule

/* sim/gain_checker.sv */
// Checker of the dynamic EQ gain computer: predicts each gain beat and compares it.
module gain_checker #(
  parameter int SAMPLE_BITS = deg_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [deg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [deg_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  deg_item_if                                item,
  deg_result_if                              result,
  output int                                 fail_count,
  output int                                 pending
);
  import deg_pkg::*;

  typedef struct packed {
    logic signed [GAIN_BITS-1:0]  gain;
    logic signed [LEVEL_BITS-1:0] level;
  } gain_beat_t;

  gain_beat_t expected_gains[$];

  logic signed [15:0] threshold;
  logic [14:0]        ratio;
  logic [12:0]        knee;
  logic signed [13:0] makeup;
  logic [15:0]        attack;
  logic [15:0]        release_coef;
  logic [1:0]         mode;
  logic signed [13:0] manual;
  longint             envelope;

  function automatic longint decibels_of(longint lev);
    int p;
    longint unsigned m, frac, neg, mag;
    longint l2, db;
    if (lev == 0) return DB_FLOOR;
    p = 0;
    frac = 0;
    while ((lev >> (p + 1)) != 0) p++;
    m = (p <= 30) ? (longint'(lev) << (30 - p)) : (longint'(lev) >> (p - 30));
    // Sixteen fraction bits of log2 by repeated squaring of the mantissa.
    for (int i = 15; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | (64'd1 << i);
      end
    end
    l2 = (longint'(p) - (SAMPLE_BITS - 1)) * 65536 + longint'(frac);
    if (l2 >= 0) return 0;
    neg = -l2;
    mag = (neg * 64'd101008905 + (64'd1 << 31)) >> 32;
    db = -longint'(mag);
    if (db < DB_FLOOR) db = DB_FLOOR;
    return db;
  endfunction

  function automatic longint clamp_db(longint g);
    if (g > GAIN_LIMIT) return GAIN_LIMIT;
    if (g < -GAIN_LIMIT) return -GAIN_LIMIT;
    return g;
  endfunction

  function automatic longint compressor_curve(longint level_db);
    longint o, k, r, s, num, den;
    o = level_db - longint'(threshold);
    k = longint'(knee);
    r = longint'(ratio);
    if (r <= 256) return 0;
    if (2 * o <= -k) return 0;
    if (2 * o < k) begin
      s = 2 * o + k;
      num = (r - 256) * s * s;
      den = 8 * k * r;
      return -((2 * num + den) / (2 * den));
    end
    num = (r - 256) * o;
    return -((2 * num + r) / (2 * r));
  endfunction

  function automatic gain_beat_t predict_gain(longint left, longint right, longint side);
    gain_beat_t b;
    longint lev, sum, raw, c, db, g;
    if (mode == MODE_MANUAL) begin
      b.gain = GAIN_BITS'(clamp_db(longint'(manual)));
      b.level = DB_FLOOR;
      return b;
    end
    if (mode == MODE_SIDECHAIN) begin
      lev = (side > (64'd1 << (SAMPLE_BITS - 1))) ? (64'd1 << (SAMPLE_BITS - 1)) : side;
    end else begin
      sum = left + right;
      raw = (sum < 0 ? -sum : sum) >> 1;
      c = (raw > envelope) ? longint'(attack) : longint'(release_coef);
      envelope = ((c * envelope + (65536 - c) * raw + 32768) >> 16)
                 & ((64'd1 << SAMPLE_BITS) - 1);
      lev = envelope;
    end
    db = decibels_of(lev);
    g = clamp_db(compressor_curve(db) + longint'(makeup));
    b.gain = GAIN_BITS'(g);
    b.level = LEVEL_BITS'(db);
    return b;
  endfunction

  assign pending = expected_gains.size();

  always @(posedge clk) begin
    gain_beat_t want;
    if (rst) begin
      threshold <= THRESHOLD_RESET;
      ratio <= RATIO_RESET;
      knee <= KNEE_RESET;
      makeup <= '0;
      attack <= ATTACK_RESET;
      release_coef <= RELEASE_RESET;
      mode <= MODE_AUTO;
      manual <= '0;
      envelope = 0;
      fail_count = 0;
      expected_gains.delete();
    end else begin
      if (cfg_write) begin
        case (reg_index_t'(cfg_index))
          REG_THRESHOLD: threshold <= cfg_data;
          REG_RATIO:     ratio <= cfg_data[14:0];
          REG_KNEE:      knee <= cfg_data[12:0];
          REG_MAKEUP:    makeup <= cfg_data[13:0];
          REG_ATTACK:    attack <= cfg_data;
          REG_RELEASE:   release_coef <= cfg_data;
          REG_MODE:      mode <= cfg_data[1:0];
          REG_MANUAL:    manual <= cfg_data[13:0];
          default: ;
        endcase
      end
      if (item.valid && item.ready) begin
        expected_gains.push_back(predict_gain(longint'(item.sample_left),
                                              longint'(item.sample_right),
                                              longint'({40'd0, item.sidechain_level})));
      end
      if (result.valid && result.ready) begin
        if (expected_gains.size() == 0) begin
          $error("unexpected gain beat: gain_change %0d detected_level %0d",
                 result.gain_change, result.detected_level);
          fail_count++;
        end else begin
          want = expected_gains.pop_front();
          if (result.gain_change !== want.gain) begin
            $error("gain_change: expected %0d, actual %0d", want.gain, result.gain_change);
            fail_count++;
          end
          if (result.detected_level !== want.level) begin
            $error("detected_level: expected %0d, actual %0d",
                   want.level, result.detected_level);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

/* sim/tb_top.sv */
// Testbench top of the dynamic EQ gain computer: stimulus, idling and verdict.
module tb_top;
  import deg_pkg::*;

  localparam int SB = 24;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  int fail_count;
  int pending;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_ticket;

  deg_item_if #(.SAMPLE_BITS(SB)) items();
  deg_result_if results();

  dynamic_eq_gain_computer #(.SAMPLE_BITS(SB)) dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .item(items), .result(results)
  );

  gain_checker #(.SAMPLE_BITS(SB)) u_checker (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .item(items), .result(results),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #36000000;
    $display("tb_top failed");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off whenever a new ticket appears.
  initial begin
    int seen, hold;
    seen = 0;
    hold = 0;
    results.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ticket != seen) begin
        seen = hold_ticket;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        results.ready <= 1'b0;
      end else begin
        results.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_pair(logic [SB-1:0] left, logic [SB-1:0] right, logic [SB-1:0] side);
    items.valid <= 1'b1;
    items.sample_left <= left;
    items.sample_right <= right;
    items.sidechain_level <= side;
    @(posedge clk);
    while (!items.ready) @(posedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      items.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic drain();
    items.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic configure(logic [15:0] thr, logic [15:0] ratio, logic [15:0] knee,
                           logic [15:0] makeup, logic [15:0] att, logic [15:0] rel,
                           logic [15:0] mode, logic [15:0] manual);
    logic [15:0] vals[8];
    vals = '{thr, ratio, knee, makeup, att, rel, mode, manual};
    for (int i = 0; i < 8; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= CFG_INDEX_BITS'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Samples over a wide range of magnitudes so the log reaches every octave.
  function automatic logic [SB-1:0] random_sample();
    logic signed [SB-1:0] s;
    s = SB'($urandom);
    if ($urandom_range(3) == 0) return s;
    return s >>> $urandom_range(0, SB - 1);
  endfunction

  function automatic logic [SB-1:0] random_side();
    logic [SB-1:0] s;
    s = SB'($urandom);
    case ($urandom_range(5))
      0: return s;
      1: return 24'h800000;
      default: return s >> $urandom_range(1, SB);
    endcase
  endfunction

  task automatic random_config();
    logic [15:0] thr, ratio, knee, mk, md, man;
    thr = ($urandom_range(9) == 0) ? 16'($urandom) : 16'(-$urandom_range(0, 30720));
    ratio = ($urandom_range(9) == 0) ? 16'($urandom_range(0, 32767))
                                     : 16'($urandom_range(256, 25600));
    knee = ($urandom_range(9) == 0) ? 16'($urandom_range(0, 8191))
                                    : 16'($urandom_range(0, 6144));
    mk = ($urandom_range(9) == 0) ? 16'($urandom_range(0, 16383))
                                  : 16'($signed($urandom_range(0, 12288)) - 6144);
    man = 16'($urandom_range(0, 16383));
    md = ($urandom_range(9) < 7) ? 16'(MODE_AUTO)
       : ($urandom_range(2) == 0) ? 16'(MODE_SIDECHAIN)
       : ($urandom_range(1) == 0) ? 16'(MODE_MANUAL) : 16'(MODE_SPARE);
    configure(thr, ratio, knee, mk, 16'($urandom), 16'($urandom), md, man);
  endtask

  initial begin
    int phase_pct[4][2];
    phase_pct = '{'{0, 0}, '{76, 0}, '{0, 76}, '{21, 21}};
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_ticket = 0;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    items.valid <= 1'b0;
    items.sample_left <= '0;
    items.sample_right <= '0;
    items.sidechain_level <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset settings, sample extremes, zero level and a decaying envelope.
    send_pair(24'h7FFFFF, 24'h7FFFFF, 0);
    send_pair(24'h800000, 24'h800000, 0);
    send_pair(24'h7FFFFF, 24'h800000, 0);
    send_pair(0, 0, 24'hFFFFFF);
    send_pair(24'h000001, 24'h000000, 0);
    drain();
    // Instant attack, slowest release, hard knee, a steep ratio and 24 dB of makeup.
    configure(16'd0, 16'd25600, 16'd0, 16'd6144, 16'd0, 16'd65535, 16'(MODE_AUTO), 16'd0);
    send_pair(24'h7FFFFF, 24'h7FFFFF, 0);
    send_pair(24'h400000, 24'h000000, 0);
    send_pair(0, 0, 0);
    send_pair(24'h800000, 24'h000000, 0);
    drain();
    // Sidechain: zero, full scale, above full scale and a one-LSB level.
    configure(-16'sd30720, 16'd256, 16'd6144, -16'sd6144, 16'd65535, 16'd0,
              16'(MODE_SIDECHAIN), 16'd0);
    send_pair(0, 0, 0);
    send_pair(0, 0, 24'h800000);
    send_pair(0, 0, 24'hFFFFFF);
    send_pair(0, 0, 24'h000001);
    drain();
    configure(-16'sd6000, 16'd32767, 16'd8191, 16'd8191, 16'd1, 16'd1,
              16'(MODE_SIDECHAIN), 16'd0);
    send_pair(0, 0, 24'h080000);
    send_pair(0, 0, 24'h100000);
    send_pair(0, 0, 24'h000100);
    drain();
    // Manual with in-range and out-of-range values, then the spare mode code.
    configure(16'h7FFF, 16'd0, 16'd0, 16'h2000, 16'd0, 16'd0, 16'(MODE_MANUAL), 16'd7680);
    send_pair(24'h7FFFFF, 0, 0);
    drain();
    configure(16'h7FFF, 16'd0, 16'd0, 16'h2000, 16'd0, 16'd0, 16'(MODE_MANUAL), 16'h2000);
    send_pair(0, 24'h800000, 0);
    drain();
    configure(16'h8000, 16'd1000, 16'd100, 16'h1FFF, 16'd30000, 16'd30000,
              16'(MODE_MANUAL), 16'h1FFF);
    send_pair(0, 0, 0);
    drain();
    configure(16'h8000, 16'd1000, 16'd100, 16'h1FFF, 16'd30000, 16'd30000,
              16'(MODE_SPARE), 16'd0);
    send_pair(24'h123456, 24'h654321, 0);
    send_pair(24'hF00000, 24'hF00000, 0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      send_idle_pct = phase_pct[ph % 4][0];
      recv_stall_pct = phase_pct[ph % 4][1];
      if (ph == 0) begin
        configure(-16'sd3000, 16'd1024, 16'd1536, 16'd0, 16'd60000, 16'd65000,
                  16'(MODE_AUTO), 16'd0);
      end else begin
        random_config();
      end
      if (ph == 2) hold_ticket++;
      for (int n = 0; n < 216; n++) begin
        if (ph == 5 && n == 100) begin
          items.valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        send_pair(random_sample(), random_sample(), random_side());
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/deg_pkg.sv
src/deg_if.sv
src/deg_mul.sv
src/deg_div.sv
src/dynamic_eq_gain_computer.sv
sim/gain_checker.sv
sim/tb_top.sv
